@@ hw/rtl/mbhw_pkg.sv @@
// Package for the ISO media box header walker.
// Holds the transaction payload types, status codes and register indexes.
// No dependencies; every other file of the block except mbhw_stream_if imports it.
`timescale 1ns / 1ps

package mbhw_pkg;

  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] CFG_FILE_LENGTH  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_OFFSET = 8'd1;

  // Header lengths: plain header, and header with a 64-bit large size.
  localparam logic [63:0] HdrLen      = 64'd8;
  localparam logic [63:0] LargeHdrLen = 64'd16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_PARSE_ERR = 2'd2,
    ST_END       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LARGE  = 2'd1,
    PH_SKIP   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] box_type;
    logic [63:0] box_size;
    logic [63:0] box_offset;
    status_e     status;
    logic        walk_done;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [63:0]        data;
  } cfg_write_t;

endpackage

@@ hw/rtl/mbhw_stream_if.sv @@
// Valid/ready channel interface used for input, result and configuration.
// The payload type is a parameter; the types come from mbhw_pkg.
`timescale 1ns / 1ps

interface mbhw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/mbhw_in_stage.sv @@
// Input register of the box header walker: one transaction deep.
// Depends on mbhw_pkg for the input item type.
`timescale 1ns / 1ps

module mbhw_in_stage
  import mbhw_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  in_item_t item_i,
  output logic     ready_o,
  output logic     valid_o,
  output in_item_t item_o,
  input  logic     take_i
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  // The stage refills in the same cycle that the walker drains it.
  assign ready_o = !valid_q || take_i;
  assign valid_d = (valid_i && ready_o) || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

@@ hw/rtl/mbhw_walker.sv @@
// Box walker state, per-byte update logic and the result register.
// Depends on mbhw_pkg for phases, status codes and payload types.
`timescale 1ns / 1ps

module mbhw_walker
  import mbhw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  cfg_write_t cfg_i,
  input  logic       in_valid_i,
  input  in_item_t   in_item_i,
  output logic       take_o,
  output logic       out_valid_o,
  output out_item_t  out_item_o,
  input  logic       out_ready_i
);

  logic [63:0] file_length_q, file_length_d;
  logic [63:0] start_offset_q, start_offset_d;
  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [63:0] size_q, size_d;
  logic [31:0] type_q, type_d;
  logic [63:0] start_q, start_d;
  logic [63:0] remain_q, remain_d;
  logic [63:0] skip_q, skip_d;
  logic [63:0] next_start_q, next_start_d;
  logic        stopped_q, stopped_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_item_q;

  logic        restart;
  logic        step;
  logic [63:0] shifted_size;
  logic [31:0] shifted_type;
  logic        cnt_last;
  logic [63:0] fin_size;
  logic [31:0] fin_type;
  logic [63:0] fin_hlen;
  logic [64:0] fin_sum;
  logic        fin_bad;
  logic [63:0] fin_body;
  logic        res_valid;
  out_item_t   res_item;

  assign restart = cfg_we_i &&
                   (cfg_i.index == CFG_FILE_LENGTH || cfg_i.index == CFG_START_OFFSET);
  assign take_o  = in_valid_i && (!out_valid_q || out_ready_i);
  assign step    = take_o && !stopped_q && !restart;

  // Header completion checks: size bounds and offset overflow.
  // In the large-size phase the type was already complete before the size.
  always_comb begin
    shifted_size = {size_q[55:0], in_item_i.data_byte};
    shifted_type = {type_q[23:0], in_item_i.data_byte};
    cnt_last     = (hdr_cnt_q == 3'd7);
    fin_size     = (phase_q == PH_LARGE) ? shifted_size : size_q;
    fin_type     = (phase_q == PH_LARGE) ? type_q : shifted_type;
    fin_hlen     = (phase_q == PH_LARGE) ? LargeHdrLen : HdrLen;
    fin_sum      = {1'b0, start_q} + {1'b0, fin_size};
    fin_bad      = (fin_size < fin_hlen) || (fin_size > remain_q) || fin_sum[64];
    fin_body     = fin_size - fin_hlen;
  end

  // Next state.
  always_comb begin
    file_length_d  = file_length_q;
    start_offset_d = start_offset_q;
    phase_d        = phase_q;
    hdr_cnt_d      = hdr_cnt_q;
    size_d         = size_q;
    type_d         = type_q;
    start_d        = start_q;
    remain_d       = remain_q;
    skip_d         = skip_q;
    next_start_d   = next_start_q;
    stopped_d      = stopped_q;
    if (restart) begin
      if (cfg_i.index == CFG_FILE_LENGTH) begin
        file_length_d = cfg_i.data;
        remain_d      = cfg_i.data;
        start_d       = start_offset_q;
      end else begin
        start_offset_d = cfg_i.data;
        start_d        = cfg_i.data;
        remain_d       = file_length_q;
      end
      phase_d   = PH_HEADER;
      hdr_cnt_d = 3'd0;
      size_d    = '0;
      type_d    = '0;
      skip_d    = '0;
      stopped_d = 1'b0;
    end else if (step) begin
      unique case (phase_q)
        PH_SKIP: begin
          if (in_item_i.stream_end) begin
            stopped_d = 1'b1;
          end else begin
            skip_d = skip_q - 64'd1;
            if (skip_q == 64'd1) begin
              start_d   = next_start_q;
              phase_d   = PH_HEADER;
              hdr_cnt_d = 3'd0;
              size_d    = '0;
              type_d    = '0;
            end
          end
        end
        PH_LARGE, PH_HEADER: begin
          if (phase_q == PH_HEADER && hdr_cnt_q == 3'd0 && remain_q == 64'd0) begin
            stopped_d = 1'b1;
          end else if (in_item_i.stream_end) begin
            stopped_d = 1'b1;
          end else if (!cnt_last) begin
            hdr_cnt_d = hdr_cnt_q + 3'd1;
            if (phase_q == PH_LARGE || hdr_cnt_q < 3'd4) begin
              size_d = shifted_size;
            end else begin
              type_d = shifted_type;
            end
          end else if (phase_q == PH_HEADER && size_q == 64'd1) begin
            // Size field of one: a 64-bit large size follows the type.
            phase_d   = PH_LARGE;
            hdr_cnt_d = 3'd0;
            size_d    = '0;
            type_d    = shifted_type;
          end else if (fin_bad) begin
            stopped_d = 1'b1;
          end else begin
            size_d       = fin_size;
            type_d       = fin_type;
            hdr_cnt_d    = 3'd0;
            remain_d     = remain_q - fin_size;
            skip_d       = fin_body;
            next_start_d = fin_sum[63:0];
            if (fin_body == 64'd0) begin
              start_d = fin_sum[63:0];
              phase_d = PH_HEADER;
              size_d  = '0;
              type_d  = '0;
            end else begin
              phase_d = PH_SKIP;
            end
          end
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
    end
  end

  // Result of the current transaction.
  always_comb begin
    res_valid           = 1'b0;
    res_item.box_type   = '0;
    res_item.box_size   = '0;
    res_item.box_offset = start_q;
    res_item.status     = ST_PARSE_ERR;
    res_item.walk_done  = 1'b1;
    if (step) begin
      if (phase_q == PH_HEADER && hdr_cnt_q == 3'd0 && remain_q == 64'd0) begin
        res_valid       = 1'b1;
        res_item.status = ST_END;
      end else if (in_item_i.stream_end) begin
        res_valid = 1'b1;
      end else if (phase_q != PH_SKIP && cnt_last &&
                   !(phase_q == PH_HEADER && size_q == 64'd1)) begin
        res_valid          = 1'b1;
        res_item.box_type  = fin_type;
        res_item.box_size  = fin_size;
        res_item.status    = fin_bad ? ST_INVALID : ST_OK;
        res_item.walk_done = fin_bad;
      end
    end
  end

  assign out_valid_d = res_valid || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q  <= '0;
      start_offset_q <= '0;
      phase_q        <= PH_HEADER;
      hdr_cnt_q      <= '0;
      size_q         <= '0;
      type_q         <= '0;
      start_q        <= '0;
      remain_q       <= '0;
      skip_q         <= '0;
      next_start_q   <= '0;
      stopped_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      file_length_q  <= file_length_d;
      start_offset_q <= start_offset_d;
      phase_q        <= phase_d;
      hdr_cnt_q      <= hdr_cnt_d;
      size_q         <= size_d;
      type_q         <= type_d;
      start_q        <= start_d;
      remain_q       <= remain_d;
      skip_q         <= skip_d;
      next_start_q   <= next_start_d;
      stopped_q      <= stopped_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_item_q <= res_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A stopped walk produces nothing until restarted.
  a_no_result_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> !res_valid)
    else $error("result produced after the walk stopped");

  // Only a good header leaves the walk running.
  a_done_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_item_q.walk_done == (out_item_q.status != ST_OK)))
    else $error("walk_done disagrees with status");

  // The body skip never rests at a zero count.
  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> skip_q != 64'd0)
    else $error("skip phase with zero bytes left");

  // A good header never lets the remaining region length grow.
  a_remain_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_item.status == ST_OK) |=> remain_q <= $past(remain_q))
    else $error("remaining length grew after a box header");

endmodule

@@ hw/rtl/mp4_box_header_walker.sv @@
// Top level of the ISO media top-level box header walker.
// Depends on mbhw_pkg, mbhw_stream_if, mbhw_in_stage and mbhw_walker.
`timescale 1ns / 1ps

// Usage
// The block takes one file byte per input transaction on in_i (data_byte, or
// stream_end to mark the end of the stream) and walks the top-level boxes of a
// region. For every complete box header it sends one result transaction on
// out_o with the type, size and start offset; errors, an early end and the
// clean end of the region also give one result, with walk_done set, after
// which bytes are consumed silently until the walk is restarted.
// The configuration channel cfg_i writes file_length (index 0) or start_offset
// (index 1); either write restarts the walk at start_offset. Writes to other
// indexes are accepted and ignored. Write only while the block is idle.
// Path: a byte passes the input register and then the walker's update logic, and
// the result for the byte that completes a header is registered before out_o.
// The block accepts one byte per cycle unless a result waits on a stalled out_o;
// the rate is set by the header, skip and size-check update in the walker.
// If out_o stalls with a result pending, the input register holds one more
// byte and then in_i.ready drops until the result is taken.
// Reset clears both registers to zero, so an unconfigured walk ends at once
// with a clean-end result on the first byte.

module mp4_box_header_walker
  import mbhw_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  mbhw_stream_if.sink   cfg_i,
  mbhw_stream_if.sink   in_i,
  mbhw_stream_if.source out_o
);

  logic       stage_valid;
  in_item_t   stage_item;
  in_item_t   in_item;
  logic       take;
  logic       cfg_we;
  cfg_write_t cfg_item;
  out_item_t  out_item;

  // Configuration is always accepted; it goes straight to the walker's registers.
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;
  assign cfg_item    = cfg_i.payload;
  assign in_item     = in_i.payload;

  mbhw_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .item_i  (in_item),
    .ready_o (in_i.ready),
    .valid_o (stage_valid),
    .item_o  (stage_item),
    .take_i  (take)
  );

  mbhw_walker u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_i       (cfg_item),
    .in_valid_i  (stage_valid),
    .in_item_i   (stage_item),
    .take_o      (take),
    .out_valid_o (out_o.valid),
    .out_item_o  (out_item),
    .out_ready_i (out_o.ready)
  );

  assign out_o.payload = out_item;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the ISO media top-level box header walker.
// Depends on mbhw_pkg, mbhw_stream_if and mp4_box_header_walker.
// Predicts every box report in SystemVerilog and checks it field by field.
`timescale 1ns / 1ps

module testbench;
  import mbhw_pkg::*;

  // The limit is far above the slowest correct run. That run is about 600
  // bytes, each waiting out long idle stretches on both sides, plus register
  // writes and drain time.
  localparam int unsigned CycleLimit  = 200000;
  // A byte passes the input register and the walker before the block answers.
  // DrainCycles of quiet are enough for a byte still inside it.
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 500;
  // This index maps to no register. The block accepts the write and ignores it.
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 8'd7;

  // Shapes of one random region. Some are well formed, and the rest end badly
  // in one of the ways the walker has to catch, or are abandoned.
  typedef enum int {
    WALK_CLEAN,
    WALK_CUT_END,
    WALK_TINY,
    WALK_HUGE,
    WALK_WRAP,
    WALK_ABANDON
  } walk_kind_e;

  logic clk_i;
  logic rst_ni;

  mbhw_stream_if #(.payload_t(cfg_write_t)) cfg_if ();
  mbhw_stream_if #(.payload_t(in_item_t))   byte_if ();
  mbhw_stream_if #(.payload_t(out_item_t))  box_if ();

  mp4_box_header_walker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (byte_if),
    .out_o  (box_if)
  );

  // Register copies and walk state, kept by the prediction below.
  logic [63:0] cfg_file_len;
  logic [63:0] cfg_start_off;
  phase_e      walk_phase;
  logic [3:0]  hdr_cnt;
  logic [63:0] size_acc;
  logic [31:0] type_acc;
  logic [63:0] box_base;
  logic [63:0] region_left;
  logic [63:0] body_left;
  logic        walk_halted;

  out_item_t   box_reports_due[$];
  in_item_t    pending_bytes[$];
  logic [7:0]  file_img[$];
  cfg_write_t  reg_writes[$];

  int unsigned bytes_taken  = 0;
  int unsigned bytes_issued = 0;
  int unsigned items_queued = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned in_idle_pct  = 0;
  int unsigned out_idle_pct = 0;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Prediction of the walk
  // ---------------------------------------------------------------------------

  function automatic void new_header();
    walk_phase = PH_HEADER;
    hdr_cnt    = '0;
    size_acc   = '0;
    type_acc   = '0;
  endfunction

  // A write to either register and reset both start the walk over at the first box.
  function automatic void restart_walk();
    new_header();
    box_base    = cfg_start_off;
    region_left = cfg_file_len;
    body_left   = '0;
    walk_halted = 1'b0;
  endfunction

  // Any status but OK stops the walk. The reported offset is always the start
  // of the current box.
  function automatic void report_box(logic [31:0] typ, logic [63:0] size, status_e st);
    out_item_t r;
    r.box_type   = typ;
    r.box_size   = size;
    r.box_offset = box_base;
    r.status     = st;
    r.walk_done  = (st != ST_OK);
    if (st != ST_OK) walk_halted = 1'b1;
    box_reports_due.push_back(r);
  endfunction

  // The size must cover the header, fit in the region that is left, and not
  // carry the box end past the top of the 64-bit offset space.
  function automatic void close_header(logic [63:0] hlen);
    logic [63:0] box_end;
    box_end = box_base + size_acc;
    if (size_acc < hlen || size_acc > region_left || box_end < box_base) begin
      report_box(type_acc, size_acc, ST_INVALID);
    end else begin
      report_box(type_acc, size_acc, ST_OK);
      region_left = region_left - size_acc;
      body_left   = size_acc - hlen;
      if (body_left == 0) begin
        box_base = box_end;
        new_header();
      end else begin
        walk_phase = PH_SKIP;
      end
    end
  endfunction

  function automatic void walk_byte(in_item_t it);
    if (walk_halted) return;
    case (walk_phase)
      PH_SKIP: begin
        if (it.stream_end) begin
          report_box('0, '0, ST_PARSE_ERR);
        end else begin
          body_left = body_left - 64'd1;
          if (body_left == 0) begin
            box_base = box_base + size_acc;
            new_header();
          end
        end
      end
      PH_LARGE: begin
        if (it.stream_end) begin
          report_box('0, '0, ST_PARSE_ERR);
        end else begin
          size_acc = {size_acc[55:0], it.data_byte};
          hdr_cnt  = hdr_cnt + 4'd1;
          if (hdr_cnt == 4'd8) close_header(LargeHdrLen);
        end
      end
      default: begin
        // At a box boundary an empty region ends the walk cleanly, whatever
        // the item holds. The item is not taken as part of a header.
        if (hdr_cnt == 0 && region_left == 0) begin
          report_box('0, '0, ST_END);
        end else if (it.stream_end) begin
          report_box('0, '0, ST_PARSE_ERR);
        end else begin
          if (hdr_cnt < 4'd4) size_acc = {size_acc[55:0], it.data_byte};
          else type_acc = {type_acc[23:0], it.data_byte};
          hdr_cnt = hdr_cnt + 4'd1;
          if (hdr_cnt == 4'd8) begin
            // A size of one announces a 64-bit size. The type is kept.
            if (size_acc == 64'd1) begin
              walk_phase = PH_LARGE;
              hdr_cnt    = '0;
              size_acc   = '0;
            end else begin
              close_header(HdrLen);
            end
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_item(input logic [7:0] b, input logic last);
    pending_bytes.push_back('{data_byte: b, stream_end: last});
    items_queued++;
  endtask

  task automatic img_word(input logic [63:0] w, input int unsigned nbytes);
    for (int i = int'(nbytes) - 1; i >= 0; i--) file_img.push_back(w[8*i +: 8]);
  endtask

  // Appends one box to the file image. The body length is given separately,
  // so that a box can carry a bad size without a matching body.
  task automatic img_box(input logic [63:0] size, input bit big_size, input logic [31:0] typ,
                         input int unsigned body);
    if (big_size) begin
      img_word(64'd1, 4);
      img_word(64'(typ), 4);
      img_word(size, 8);
    end else begin
      img_word(size, 4);
      img_word(64'(typ), 4);
    end
    repeat (body) file_img.push_back(8'($urandom));
  endtask

  task automatic send_bytes(input int unsigned lo, input int unsigned hi);
    for (int unsigned i = lo; i < hi; i++) queue_item(file_img[i], 1'b0);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || bytes_taken != bytes_issued ||
           box_reports_due.size() != 0) @(posedge clk_i);
  endtask

  // The last byte of a phase may cause no report. Extra quiet cycles let it
  // pass through the block before the registers are touched.
  task automatic go_idle();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Register writes go back to back. Valid stays high between them, so it
  // is never lowered and raised in the same step.
  task automatic apply_reg_writes();
    while (reg_writes.size() != 0) begin
      @(negedge clk_i);
      cfg_if.payload <= reg_writes.pop_front();
      cfg_if.valid   <= 1'b1;
      do @(posedge clk_i); while (!cfg_if.ready);
      case (cfg_if.payload.index)
        CFG_FILE_LENGTH: begin
          cfg_file_len = cfg_if.payload.data;
          restart_walk();
        end
        CFG_START_OFFSET: begin
          cfg_start_off = cfg_if.payload.data;
          restart_walk();
        end
        default: ;
      endcase
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Byte driver. It offers the next pending byte once the previous one is
  // taken and skips cycles at the sender's idle rate. The result ready is
  // also driven here, at the receiver's idle rate.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!byte_if.valid || bytes_taken == bytes_issued) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
          byte_if.payload <= pending_bytes.pop_front();
          byte_if.valid   <= 1'b1;
          bytes_issued++;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
      box_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Each byte transaction updates the prediction at the edge that accepts it.
  always @(posedge clk_i) begin
    if (byte_if.valid && byte_if.ready) begin
      bytes_taken++;
      walk_byte(byte_if.payload);
    end
  end

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Each accepted report is compared with the oldest one predicted.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (box_if.valid && box_if.ready) begin
      if (box_reports_due.size() == 0) begin
        $display("%0t: unexpected report, type %h size %h offset %h status %0d done %b",
                 $time, box_if.payload.box_type, box_if.payload.box_size,
                 box_if.payload.box_offset, box_if.payload.status, box_if.payload.walk_done);
        fail_count++;
      end else begin
        want = box_reports_due.pop_front();
        check_field("box_type", want.box_type, box_if.payload.box_type);
        check_field("box_size", want.box_size, box_if.payload.box_size);
        check_field("box_offset", want.box_offset, box_if.payload.box_offset);
        check_field("status", 64'(want.status), 64'(box_if.payload.status));
        check_field("walk_done", 64'(want.walk_done), 64'(box_if.payload.walk_done));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [63:0] size;
    logic [63:0] total;
    logic [63:0] prefix;
    logic [63:0] new_len;
    logic [63:0] new_start;
    bit          big_size;
    bit          paused_once;
    int unsigned n_boxes;
    int unsigned body;
    int unsigned cut;
    int unsigned pick;
    walk_kind_e  kind;

    rst_ni          = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.payload  = '0;
    byte_if.valid   = 1'b0;
    byte_if.payload = '0;
    box_if.ready    = 1'b0;
    cfg_file_len    = '0;
    cfg_start_off   = '0;
    paused_once     = 1'b0;
    restart_walk();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Both registers reset to zero, so the first byte ends the walk cleanly.
    // The stream end after it falls on a stopped walk and is dropped.
    queue_item(8'hFF, 1'b0);
    queue_item(8'h00, 1'b1);
    go_idle();

    // A write to an index with no register leaves the walk stopped.
    reg_writes.push_back('{index: CfgIdxUnused, data: '1});
    apply_reg_writes();
    queue_item(8'h00, 1'b0);
    go_idle();

    // Two boxes just below the top of the offset space. The first fits and
    // has an all-ones type. The second is a large-size box whose end wraps
    // past the top, so its size is flagged invalid.
    reg_writes.push_back('{index: CFG_FILE_LENGTH, data: 64'd32});
    reg_writes.push_back('{index: CFG_START_OFFSET, data: 64'hFFFF_FFFF_FFFF_FFEF});
    apply_reg_writes();
    img_box(64'd8, 1'b0, 32'hFFFF_FFFF, 0);
    img_box(64'd16, 1'b1, 32'h0000_0000, 0);
    send_bytes(0, file_img.size());
    go_idle();

    // Random regions. The idle pattern changes with progress: first the
    // sender idles lightly and the receiver heavily, then the reverse, then
    // neither idles.
    items_queued = 0;
    while (items_queued < RandomItems) begin
      if (items_queued < RandomItems / 3) begin
        in_idle_pct  = 31;
        out_idle_pct = 84;
      end else if (items_queued < 2 * RandomItems / 3) begin
        in_idle_pct  = 84;
        out_idle_pct = 31;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end

      pick = $urandom_range(9);
      case (pick)
        0, 1, 2, 3: kind = WALK_CLEAN;
        4, 5:       kind = WALK_CUT_END;
        6:          kind = WALK_TINY;
        7:          kind = WALK_HUGE;
        8:          kind = WALK_WRAP;
        default:    kind = WALK_ABANDON;
      endcase

      // Small boxes keep the reports frequent. About one box in five has a
      // 64-bit size. The last box carries the fault of the chosen shape.
      file_img.delete();
      n_boxes = $urandom_range(5, 1);
      total   = '0;
      prefix  = '0;
      for (int unsigned b = 0; b < n_boxes; b++) begin
        big_size = ($urandom_range(4) == 0);
        size     = big_size ? 64'($urandom_range(40, 16)) : 64'($urandom_range(36, 8));
        if (b == n_boxes - 1) begin
          prefix = total;
          if (kind == WALK_TINY) begin
            // A plain size of one would mean a large size, so it is skipped.
            size = 64'($urandom_range(6));
            if (size != 0) size = size + 64'd1;
            if (big_size) size = 64'($urandom_range(15));
          end else if (kind == WALK_HUGE && $urandom_range(1) == 0) begin
            size = big_size ? {32'($urandom), 32'($urandom)} : 64'($urandom);
          end
        end
        if (size >= (big_size ? LargeHdrLen : HdrLen) && size < 64'd64)
          body = int'(size) - (big_size ? 16 : 8);
        else
          body = 0;
        img_box(size, big_size, $urandom, body);
        total = total + size;
      end

      pick = $urandom_range(7);
      case (pick)
        0, 1, 2: new_start = '0;
        3, 4, 5: new_start = 64'($urandom);
        6:       new_start = {32'($urandom), 32'($urandom)};
        default: new_start = '1;
      endcase

      case (kind)
        WALK_CLEAN, WALK_ABANDON: new_len = total;
        WALK_CUT_END, WALK_TINY:  new_len = ($urandom_range(1) == 0) ? total : '1;
        WALK_HUGE: begin
          if (size > 64'd64) new_len = prefix + 64'($urandom_range(40));
          else new_len = total - 64'($urandom_range(int'(size), 1));
        end
        default: begin
          // The last box starts in range, but its end wraps past the top.
          new_len   = '1;
          new_start = 64'd0 - prefix - 64'($urandom_range(int'(size) - 1, 1));
        end
      endcase

      reg_writes.push_back('{index: CFG_FILE_LENGTH, data: new_len});
      reg_writes.push_back('{index: CFG_START_OFFSET, data: new_start});
      apply_reg_writes();

      case (kind)
        WALK_CUT_END: cut = $urandom_range(file_img.size());
        WALK_ABANDON: cut = $urandom_range(file_img.size() - 1);
        default:      cut = file_img.size();
      endcase

      // Now and then the sender holds back in mid-region until the block has
      // nothing left to report. This happens at least once.
      if (cut >= 2 && (!paused_once || $urandom_range(7) == 0)) begin
        paused_once = 1'b1;
        send_bytes(0, cut / 2);
        wait_drained();
        send_bytes(cut / 2, cut);
      end else begin
        send_bytes(0, cut);
      end

      // The tail either ends the walk or lands on a stopped walk and is
      // dropped. An abandoned region is left mid-box for the next restart.
      case (kind)
        WALK_CLEAN: begin
          queue_item(8'($urandom), 1'($urandom_range(1)));
          repeat ($urandom_range(2)) queue_item(8'($urandom), 1'($urandom_range(1)));
        end
        WALK_CUT_END: begin
          queue_item(8'($urandom), 1'b1);
          if ($urandom_range(1) == 0) queue_item(8'($urandom), 1'b0);
        end
        WALK_ABANDON: ;
        default: queue_item(8'($urandom), 1'($urandom_range(1)));
      endcase
      go_idle();
    end

    go_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
